// ===== hw/rtl/cba_pkg.sv =====
// Package for the contiguous block allocator: item types, field widths and codes.
// Used by cba_map, cba_engine and contiguous_block_allocator; depends on nothing.
`default_nettype none

package cba_pkg;

   // Fixed field widths of the items.
   localparam int LEN_W   = 16;
   localparam int BLK_W   = 6;
   localparam int COUNT_W = 7;

   // Default geometry of the disk.
   localparam int NUM_BLOCKS_DEF  = 64;
   localparam int BLOCK_BYTES_DEF = 1024;

   // Function codes of an input item.
   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   // Status codes of a result item.
   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_NO_SPACE = 1'b1;

   typedef struct packed {
      logic               func;
      logic [LEN_W-1:0]   byte_length;
      logic [BLK_W-1:0]   free_start;
      logic [COUNT_W-1:0] free_count;
   } req_type;

   typedef struct packed {
      logic               status;
      logic [BLK_W-1:0]   run_start;
      logic [COUNT_W-1:0] block_count;
   } rsp_type;

   // One access to the occupancy map per cycle: a read of idx, and a write when wr_en.
   typedef struct packed {
      logic             wr_en;
      logic             wr_val;
      logic [BLK_W-1:0] idx;
   } map_cmd_type;

endpackage

`default_nettype wire

// ===== hw/rtl/cba_map.sv =====
// Occupancy bitmap of the disk blocks with one single-bit read and write port.
// Depends on cba_pkg for the map command struct.
`default_nettype none

module cba_map
   import cba_pkg::*;
#(
   parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire map_cmd_type map_cmd,
   output logic             map_used
);

   localparam int IDX_W = $clog2(NUM_BLOCKS);

   logic [NUM_BLOCKS-1:0] map_ff;
   logic [IDX_W-1:0]      idx;

   assign idx = map_cmd.idx[IDX_W-1:0];

   // Reset leaves every block free, as a format does.
   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff <= '0;
      end else if (map_cmd.wr_en) begin
         map_ff[idx] <= map_cmd.wr_val;
      end
   end

   // Occupancy of the block under the cursor.
   assign map_used = map_ff[idx];

endmodule

`default_nettype wire

// ===== hw/rtl/cba_engine.sv =====
// Sequencer of the allocator: block count by repeated subtraction, first-fit scan,
// then marking or clearing one block per cycle. Depends on cba_pkg.
`default_nettype none

module cba_engine
   import cba_pkg::*;
#(
   parameter int NUM_BLOCKS  = NUM_BLOCKS_DEF,
   parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_item,
   output map_cmd_type      map_cmd,
   input  wire logic        map_used,
   input  wire logic        res_free,
   output logic             res_load,
   output rsp_type          res_item
);

   localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
   localparam int LEN_X = LEN_W + 1;
   localparam logic [LEN_X-1:0]   BB_EXT  = LEN_X'(BLOCK_BYTES);
   localparam logic [CNT_W-1:0]   NB_CNT  = CNT_W'(NUM_BLOCKS);
   localparam logic [CNT_W-1:0]   LAST    = CNT_W'(NUM_BLOCKS - 1);
   localparam logic [COUNT_W-1:0] NB_WIDE = COUNT_W'(NUM_BLOCKS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SCAN,
      ST_WRITE,
      ST_FINISH
   } state_type;

   state_type          state_ff, state_in;
   logic               func_ff, func_in;
   logic [LEN_W-1:0]   rem_ff, rem_in;
   logic [CNT_W-1:0]   need_ff, need_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   run_ff, run_in;
   logic [CNT_W-1:0]   left_ff, left_in;
   rsp_type            res_ff, res_in;

   logic [LEN_X-1:0]   diff;
   logic               len_ge;
   logic [CNT_W-1:0]   run_inc;
   logic               hit;
   logic [CNT_W-1:0]   start_calc;
   logic [COUNT_W-1:0] start_wide;
   logic               free_past;
   logic [COUNT_W-1:0] free_avail;
   logic [COUNT_W-1:0] free_done;

   // Subtractor for the block count, and the free-run clip.
   always_comb begin
      diff       = {1'b0, rem_ff} - BB_EXT;
      len_ge     = !diff[LEN_W];
      start_wide = {1'b0, req_item.free_start};
      free_past  = start_wide >= NB_WIDE;
      free_avail = NB_WIDE - start_wide;
      if (free_past) begin
         free_done = '0;
      end else if (req_item.free_count < free_avail) begin
         free_done = req_item.free_count;
      end else begin
         free_done = free_avail;
      end
   end

   // Run tracking during the first-fit scan.
   always_comb begin
      run_inc    = run_ff + CNT_W'(1);
      hit        = !map_used && (run_inc == need_ff);
      start_calc = idx_ff + CNT_W'(1) - need_ff;
   end

   // Next-state logic of the sequencer.
   always_comb begin
      state_in = state_ff;
      func_in  = func_ff;
      rem_in   = rem_ff;
      need_in  = need_ff;
      idx_in   = idx_ff;
      run_in   = run_ff;
      left_in  = left_ff;
      res_in   = res_ff;
      res_load = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               func_in = req_item.func;
               if (req_item.func == FUNC_ALLOC) begin
                  rem_in   = req_item.byte_length;
                  need_in  = CNT_W'(1);
                  state_in = ST_DIVIDE;
               end else begin
                  idx_in             = CNT_W'(req_item.free_start);
                  left_in            = CNT_W'(free_done);
                  res_in.status      = STATUS_OK;
                  res_in.run_start   = '0;
                  res_in.block_count = free_done;
                  state_in           = (free_done == '0) ? ST_FINISH : ST_WRITE;
               end
            end
         end
         ST_DIVIDE: begin
            if (len_ge && (need_ff < NB_CNT)) begin
               rem_in  = diff[LEN_W-1:0];
               need_in = need_ff + CNT_W'(1);
            end else if (need_ff >= NB_CNT) begin
               res_in.status      = STATUS_NO_SPACE;
               res_in.run_start   = '0;
               res_in.block_count = '0;
               state_in           = ST_FINISH;
            end else begin
               idx_in   = '0;
               run_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            run_in = map_used ? '0 : run_inc;
            if (hit) begin
               idx_in             = start_calc;
               left_in            = need_ff;
               res_in.status      = STATUS_OK;
               res_in.run_start   = BLK_W'(start_calc);
               res_in.block_count = COUNT_W'(need_ff);
               state_in           = ST_WRITE;
            end else if (idx_ff == LAST) begin
               res_in.status      = STATUS_NO_SPACE;
               res_in.run_start   = '0;
               res_in.block_count = '0;
               state_in           = ST_FINISH;
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         ST_WRITE: begin
            idx_in  = idx_ff + CNT_W'(1);
            left_in = left_ff - CNT_W'(1);
            if (left_ff == CNT_W'(1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (res_free) begin
               res_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and working registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      func_ff <= func_in;
      rem_ff  <= rem_in;
      need_ff <= need_in;
      idx_ff  <= idx_in;
      run_ff  <= run_in;
      left_ff <= left_in;
      res_ff  <= res_in;
   end

   // Map access: the cursor is read while scanning and written while marking or clearing.
   always_comb begin
      map_cmd.wr_en  = (state_ff == ST_WRITE);
      map_cmd.wr_val = (func_ff == FUNC_ALLOC);
      map_cmd.idx    = BLK_W'(idx_ff);
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign res_item  = res_ff;

   // A marking pass always has blocks left and stays inside the map.
   a_write_in_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |-> (left_ff != '0) && (idx_ff < NB_CNT))
      else $error("marking pass out of range");

   // A scan only runs for a need the map can hold.
   a_scan_need : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (need_ff != '0) && (need_ff < NB_CNT))
      else $error("scan started with an impossible block count");

   // A result is only loaded into a free output register.
   a_load_free : assert property (@(posedge clock) disable iff (reset)
      res_load |-> res_free)
      else $error("result loaded over a waiting item");

   // A run found by the scan leads to a marking pass over all of its blocks.
   a_run_fits : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) && hit |=> (state_ff == ST_WRITE) && (left_ff == need_ff))
      else $error("run found but marking pass not set up");

endmodule

`default_nettype wire

// ===== hw/rtl/contiguous_block_allocator.sv =====
// Top level of the contiguous block allocator: sequencer, occupancy map and result register.
// Depends on cba_pkg, cba_map and cba_engine.
//
// First-fit allocator over a bitmap of NUM_BLOCKS disk blocks, all free after reset. An
// allocate item needs byte_length / BLOCK_BYTES + 1 blocks and returns the start of the
// lowest free run of that length; a free item clears a run clipped at the map end. The
// block works on one item at a time. An allocate item finds the quotient q by subtracting
// BLOCK_BYTES once per cycle (at most NUM_BLOCKS - 1 times, followed by a step that ends
// the division), then scans at most NUM_BLOCKS blocks and marks the blocks of the run; a
// free item clears its blocks one by one and goes straight to its result when nothing
// is cleared. The pace is set by the single subtractor of the division and the
// single-bit port of the map. A finished item waits in an output register, so a new item
// may be taken while it waits.
`default_nettype none

module contiguous_block_allocator
   import cba_pkg::*;
#(
   parameter int NUM_BLOCKS  = NUM_BLOCKS_DEF,
   parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_item,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_item
);

   map_cmd_type map_cmd;
   logic        map_used;
   logic        res_free;
   logic        res_load;
   rsp_type     res_item;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_item_ff, rsp_item_in;

   cba_engine #(
      .NUM_BLOCKS  (NUM_BLOCKS),
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .map_cmd   (map_cmd),
      .map_used  (map_used),
      .res_free  (res_free),
      .res_load  (res_load),
      .res_item  (res_item)
   );

   cba_map #(
      .NUM_BLOCKS (NUM_BLOCKS)
   ) u_map (
      .clock    (clock),
      .reset    (reset),
      .map_cmd  (map_cmd),
      .map_used (map_used)
   );

   // Output register: free when empty or being taken this cycle.
   always_comb begin
      res_free     = !rsp_valid_ff || rsp_ready;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_item_in  = rsp_item_ff;
      if (res_load) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = res_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

`default_nettype wire

// ===== tb/sv/contiguous_block_allocator_test.sv =====
// Self-checking testbench for contiguous_block_allocator: first-fit allocation and freeing.
// Depends on cba_pkg and the allocator RTL; predicts every result from its own occupancy map.
`timescale 1ns / 1ps

module contiguous_block_allocator_test
   import cba_pkg::*;
();

   localparam int NUM_BLOCKS    = NUM_BLOCKS_DEF;
   localparam int BLOCK_BYTES   = BLOCK_BYTES_DEF;
   localparam int STALL_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 200;
   localparam int REPORT_LIMIT  = 10;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_item  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_item;

   // Items still to be offered, and the outcomes predicted for accepted ones.
   req_type queued_requests[$];
   rsp_type awaited_outcomes[$];

   // Shadow copy of the disk occupancy, one bit per block.
   logic [NUM_BLOCKS-1:0] block_map = '0;

   bit      steady     = 1'b0;
   int      mismatches = 0;
   int      idle_cycles = 0;
   rsp_type wanted;

   contiguous_block_allocator #(
      .NUM_BLOCKS  (NUM_BLOCKS),
      .BLOCK_BYTES (BLOCK_BYTES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   always #4 clock = ~clock;

   // Applies one item to the shadow map and returns the outcome the block should report.
   function automatic rsp_type apply_to_map(req_type r);
      rsp_type o;
      int      need;
      int      run;
      int      first;
      int      cleared;
      o = '0;
      if (r.func == FUNC_ALLOC) begin
         need  = int'(r.byte_length) / BLOCK_BYTES + 1;
         first = -1;
         run   = 0;
         if (need < NUM_BLOCKS) begin
            for (int b = 0; b < NUM_BLOCKS; b++) begin
               if (block_map[b]) begin
                  run = 0;
               end else begin
                  run++;
                  if (run == need && first < 0) first = b + 1 - need;
               end
            end
         end
         if (first < 0) begin
            o.status = STATUS_NO_SPACE;
         end else begin
            for (int i = 0; i < need; i++) block_map[first + i] = 1'b1;
            o.status      = STATUS_OK;
            o.run_start   = first[BLK_W-1:0];
            o.block_count = need[COUNT_W-1:0];
         end
      end else begin
         cleared = 0;
         for (int i = 0; i < int'(r.free_count); i++) begin
            if (int'(r.free_start) + i >= NUM_BLOCKS) break;
            block_map[int'(r.free_start) + i] = 1'b0;
            cleared++;
         end
         o.status      = STATUS_OK;
         o.block_count = cleared[COUNT_W-1:0];
      end
      return o;
   endfunction

   // The fields an item does not use are filled with noise.
   function automatic req_type alloc_item(logic [LEN_W-1:0] len);
      req_type r;
      r.func        = FUNC_ALLOC;
      r.byte_length = len;
      r.free_start  = BLK_W'($urandom);
      r.free_count  = COUNT_W'($urandom);
      return r;
   endfunction

   function automatic req_type free_item(logic [BLK_W-1:0] start, logic [COUNT_W-1:0] count);
      req_type r;
      r.func        = FUNC_FREE;
      r.byte_length = LEN_W'($urandom);
      r.free_start  = start;
      r.free_count  = count;
      return r;
   endfunction

   // Queues n random items in phases that fill, churn, drain or scramble the map.
   task automatic push_random(int n);
      int mode;
      int alloc_pct;
      int k;
      while (n > 0) begin
         k = $urandom_range(9);
         mode = (k < 4) ? 0 : (k < 7) ? 1 : (k < 9) ? 2 : 3;
         alloc_pct = (mode == 0) ? 85 : (mode == 2) ? 20 : 50;
         for (int i = 0; i < 40 && n > 0; i++, n--) begin
            k = $urandom_range(99);
            if (mode == 3) begin
               if ($urandom_range(1) == 0)
                  queued_requests.push_back(alloc_item(LEN_W'($urandom)));
               else
                  queued_requests.push_back(free_item(BLK_W'($urandom),
                                                      COUNT_W'($urandom)));
            end else if (mode == 2 && $urandom_range(49) == 0) begin
               queued_requests.push_back(free_item('0, COUNT_W'(NUM_BLOCKS)));
            end else if ($urandom_range(99) < alloc_pct) begin
               if (k < 70)
                  queued_requests.push_back(alloc_item(LEN_W'($urandom_range(0, 4095))));
               else if (k < 90)
                  queued_requests.push_back(alloc_item(LEN_W'($urandom_range(0, 16383))));
               else
                  queued_requests.push_back(alloc_item(LEN_W'($urandom)));
            end else begin
               if (k < 80)
                  queued_requests.push_back(free_item(BLK_W'($urandom),
                                                      COUNT_W'($urandom_range(1, 12))));
               else if (k < 95)
                  queued_requests.push_back(free_item(BLK_W'($urandom),
                                                      COUNT_W'($urandom_range(0, 64))));
               else
                  queued_requests.push_back(free_item(BLK_W'($urandom),
                                                      COUNT_W'($urandom_range(65, 127))));
            end
         end
      end
   endtask

   // Holds the sender back until every offered item has been answered.
   task automatic wait_settled();
      do @(negedge clock);
      while (queued_requests.size() != 0 || req_valid || awaited_outcomes.size() != 0);
   endtask

   // Driver: offers queued items, predicting each outcome as its item is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_item  <= '0;
      end else begin
         if (req_valid && req_ready) awaited_outcomes.push_back(apply_to_map(req_item));
         if (!req_valid || req_ready) begin
            if (queued_requests.size() != 0 && (steady || $urandom_range(99) >= 31)) begin
               req_valid <= 1'b1;
               req_item  <= queued_requests.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compares each accepted result with the oldest outstanding prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_outcomes.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("unexpected result item: status %0d start %0d count %0d",
                           rsp_item.status, rsp_item.run_start, rsp_item.block_count);
            end else begin
               wanted = awaited_outcomes.pop_front();
               if (rsp_item.status !== wanted.status ||
                   rsp_item.run_start !== wanted.run_start ||
                   rsp_item.block_count !== wanted.block_count) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display("result mismatch: expected status %0d start %0d count %0d, %s",
                              wanted.status, wanted.run_start, wanted.block_count,
                              $sformatf("got status %0d start %0d count %0d",
                                        rsp_item.status, rsp_item.run_start,
                                        rsp_item.block_count));
               end
            end
         end
         rsp_ready <= steady || ($urandom_range(99) >= 31);
      end
   end

   // Watchdog: a long run of cycles without any handshake means the block has hung.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("contiguous_block_allocator_test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      // Directed part: size limits, clipping, full map, holes and run restarts.
      queued_requests.push_back(alloc_item(16'd0));
      queued_requests.push_back(alloc_item(16'd1023));
      queued_requests.push_back(alloc_item(16'd1024));
      queued_requests.push_back(alloc_item(16'hFFFF));
      queued_requests.push_back(alloc_item(16'd64512));
      queued_requests.push_back(alloc_item(16'd64511));
      queued_requests.push_back(free_item(6'd0, 7'd0));
      queued_requests.push_back(free_item(6'd0, 7'd64));
      queued_requests.push_back(alloc_item(16'd64511));
      queued_requests.push_back(alloc_item(16'd0));
      queued_requests.push_back(alloc_item(16'd0));
      queued_requests.push_back(free_item(6'd63, 7'd127));
      queued_requests.push_back(free_item(6'd10, 7'd5));
      queued_requests.push_back(alloc_item(16'd5119));
      queued_requests.push_back(free_item(6'd20, 7'd3));
      queued_requests.push_back(free_item(6'd30, 7'd2));
      queued_requests.push_back(alloc_item(16'd2048));
      queued_requests.push_back(alloc_item(16'd1024));
      queued_requests.push_back(alloc_item(16'd0));
      queued_requests.push_back(free_item(6'd5, 7'd1));
      queued_requests.push_back(free_item(6'd5, 7'd1));
      queued_requests.push_back(free_item(6'd0, 7'd64));
      queued_requests.push_back(alloc_item(16'd2048));
      queued_requests.push_back(free_item(6'd1, 7'd1));
      queued_requests.push_back(alloc_item(16'd1024));

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      wait_settled();
      push_random(900);
      wait_settled();

      // A stretch where neither side idles.
      steady = 1'b1;
      push_random(300);
      wait_settled();
      steady = 1'b0;

      push_random(550);
      wait_settled();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("contiguous_block_allocator_test passed");
      else
         $display("contiguous_block_allocator_test failed");
      $finish;
   end

endmodule
